/* sv/lhc_pkg.sv */
// lhc_pkg: shared types and constants for the LRU handle cache.
// No dependencies; used by lhc_ctrl, lhc_datapath and lru_handle_cache_top.
`default_nettype none

package lhc_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HANDLE_W = 64;

  // result status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_FILL_FAIL = 1'b1;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch request beat and the key match vector
    logic commit;   // update recency order, load the result register
  } cmd_t;

endpackage

`default_nettype wire

/* sv/lru_handle_cache_top.sv */
// lru_handle_cache_top: fully associative LRU cache of key/handle pairs.
// A beat is latched on accept; in ST_UPDATE its result loads once the result register is free.
// One request at a time: the registered key compare is followed by the
// recency-order update, which must land before the next compare.
// Reset: async, active low; all slots hold key 0 / handle 0, slot 0 most recent.
// Depends on lhc_pkg, lhc_ctrl, lhc_datapath.
`default_nettype none

module lru_handle_cache_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [lhc_pkg::KEY_W-1:0]     lookup_key_i,
  input  wire logic [lhc_pkg::HANDLE_W-1:0]  fill_handle_i,
  input  wire logic                          fill_ok_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               hit_o,
  output logic [lhc_pkg::HANDLE_W-1:0]       handle_out_o,
  output logic [lhc_pkg::HANDLE_W-1:0]       evicted_handle_o,
  output logic                               evicted_valid_o,
  output logic                               status_o
);

  // Slots are kept physically in recency order. A request beat is compared
  // against every slot as it is accepted; the match vector is registered.
  // In UPDATE the nearest-front match (or, on a filled miss, the back slot) is
  // resolved, the slots shift unless the fill failed, and the result is loaded
  // into the output register. That step waits while it holds a stalled beat.
  lhc_pkg::cmd_t cmd;

  lhc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lhc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .lookup_key_i     (lookup_key_i),
    .fill_handle_i    (fill_handle_i),
    .fill_ok_i        (fill_ok_i),
    .hit_o            (hit_o),
    .handle_out_o     (handle_out_o),
    .evicted_handle_o (evicted_handle_o),
    .evicted_valid_o  (evicted_valid_o),
    .status_o         (status_o)
  );

  // one request in flight: the cycle after an accept never accepts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while previous one in flight");

  // an eviction only comes with a fill miss
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(evicted_valid_o && (hit_o || status_o)))
    else $error("eviction reported on hit or failed fill");

  // failed fill returns no handle and no hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (!hit_o && handle_out_o == '0))
    else $error("failed fill carries hit or handle");

  // commit only when the result register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

/* sv/lhc_ctrl.sv */
// lhc_ctrl: request sequencer and result-valid tracking for the LRU handle cache.
// Depends on lhc_pkg (state_e, cmd_t).
`default_nettype none

module lhc_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output lhc_pkg::cmd_t     cmd_o
);

  lhc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != lhc_pkg::ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.commit   = 1'b0;
    unique case (state_q)
      lhc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lhc_pkg::ST_UPDATE;
        end
      end
      lhc_pkg::ST_UPDATE: begin
        // hold here until the result register can take the beat
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = lhc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lhc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lhc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* sv/lhc_datapath.sv */
// lhc_datapath: recency-ordered key/handle slots, parallel key compare,
// move-to-front / evict update and the result register.
// Depends on lhc_pkg (widths, status codes, cmd_t).
`default_nettype none

module lhc_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lhc_pkg::cmd_t                 cmd_i,
  input  wire logic [lhc_pkg::KEY_W-1:0]     lookup_key_i,
  input  wire logic [lhc_pkg::HANDLE_W-1:0]  fill_handle_i,
  input  wire logic                          fill_ok_i,
  output logic                               hit_o,
  output logic [lhc_pkg::HANDLE_W-1:0]       handle_out_o,
  output logic [lhc_pkg::HANDLE_W-1:0]       evicted_handle_o,
  output logic                               evicted_valid_o,
  output logic                               status_o
);

  // slot i holds the entry of recency rank i: slot 0 is most recent
  logic [lhc_pkg::KEY_W-1:0]    key_q    [ENTRIES];
  logic [lhc_pkg::KEY_W-1:0]    key_d    [ENTRIES];
  logic [lhc_pkg::HANDLE_W-1:0] handle_q [ENTRIES];
  logic [lhc_pkg::HANDLE_W-1:0] handle_d [ENTRIES];

  // request latched at capture
  logic [lhc_pkg::KEY_W-1:0]    req_key_q;
  logic [lhc_pkg::HANDLE_W-1:0] req_handle_q;
  logic                         req_ok_q;
  logic [ENTRIES-1:0]           match_q, match_d;

  // result register
  logic                         hit_q;
  logic [lhc_pkg::HANDLE_W-1:0] handle_out_q;
  logic [lhc_pkg::HANDLE_W-1:0] evicted_handle_q;
  logic                         evicted_valid_q;
  logic                         status_q;

  logic [ENTRIES-1:0]           first_hit;  // one-hot, match nearest front
  logic [ENTRIES-1:0]           above_hit;  // slots in front of the hit
  logic                         any_hit;
  logic [lhc_pkg::HANDLE_W-1:0] hit_handle;
  logic                         do_fill;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_d[i] = (key_q[i] == lookup_key_i);
    end
  end

  assign any_hit   = |match_q;
  assign first_hit = match_q & (~match_q + ENTRIES'(1));
  assign above_hit = first_hit - ENTRIES'(1);
  assign do_fill   = !any_hit && req_ok_q;

  always_comb begin
    hit_handle = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_handle = hit_handle | (handle_q[i] & {lhc_pkg::HANDLE_W{first_hit[i]}});
    end
  end

  // hit: slots ahead of the hit slide back one, hit goes to slot 0
  // fill: everything slides back one, the last slot drops out
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      key_d[i]    = key_q[i];
      handle_d[i] = handle_q[i];
    end
    if (any_hit || do_fill) begin
      key_d[0]    = req_key_q;
      handle_d[0] = any_hit ? hit_handle : req_handle_q;
    end
    for (int i = 1; i < ENTRIES; i++) begin
      if (any_hit ? above_hit[i-1] : do_fill) begin
        key_d[i]    = key_q[i-1];
        handle_d[i] = handle_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        key_q[i]    <= '0;
        handle_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        key_q[i]    <= key_d[i];
        handle_q[i] <= handle_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_key_q    <= lookup_key_i;
      req_handle_q <= fill_handle_i;
      req_ok_q     <= fill_ok_i;
      match_q      <= match_d;
    end
    if (cmd_i.commit) begin
      hit_q            <= any_hit;
      handle_out_q     <= any_hit ? hit_handle : (do_fill ? req_handle_q : '0);
      evicted_handle_q <= do_fill ? handle_q[ENTRIES-1] : '0;
      evicted_valid_q  <= do_fill;
      status_q         <= (any_hit || do_fill) ? lhc_pkg::STATUS_OK
                                               : lhc_pkg::STATUS_FILL_FAIL;
    end
  end

  assign hit_o            = hit_q;
  assign handle_out_o     = handle_out_q;
  assign evicted_handle_o = evicted_handle_q;
  assign evicted_valid_o  = evicted_valid_q;
  assign status_o         = status_q;

endmodule

`default_nettype wire
